>>> rtl/cdbd_pkg.sv
// ----------------------------------------------------------------------------
// cdbd_pkg
// Shared types and constants for the calendar days-between-dates block.
// ----------------------------------------------------------------------------
package cdbd_pkg;

    // supported year range and calendar constants
    localparam logic [11:0] YEAR_MIN   = 12'd1900;
    localparam logic [11:0] YEAR_MAX   = 12'd2100;
    localparam logic [3:0]  MONTH_JAN  = 4'd1;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [3:0]  MONTH_APR  = 4'd4;
    localparam logic [3:0]  MONTH_JUN  = 4'd6;
    localparam logic [3:0]  MONTH_SEP  = 4'd9;
    localparam logic [3:0]  MONTH_NOV  = 4'd11;
    localparam logic [3:0]  MONTH_DEC  = 4'd12;
    localparam logic [4:0]  DAYS_LONG  = 5'd31;
    localparam logic [4:0]  DAYS_SHORT = 5'd30;
    localparam logic [4:0]  DAYS_FEB   = 5'd28;
    localparam logic [4:0]  DAYS_FEB_L = 5'd29;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_ORDER   = 2'd2;

    typedef struct packed {
        logic [5:0]  entry_day;
        logic [3:0]  entry_month;
        logic [11:0] entry_year;
        logic [5:0]  exit_day;
        logic [3:0]  exit_month;
        logic [11:0] exit_year;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] day_count;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK_ENTRY,
        ST_CHK_EXIT,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

>>> rtl/calendar_days_between_dates.sv
// ----------------------------------------------------------------------------
// calendar_days_between_dates
// Checks two dates and counts the days between them by walking months.
// ----------------------------------------------------------------------------
// An item goes from acceptance through the entry check, the exit check and
// a walk over M months, where M is the number of months walked from the entry
// month to the exit month (0 to 2411), to a result in the output register; an
// invalid or misordered pair skips the walk. The time is set by the month walk:
// a single month-length unit checks the entry date, then the exit date, then
// adds one month length per cycle. The block takes one item at a time and
// is not ready until the result has been loaded into the output register.
// ----------------------------------------------------------------------------
module calendar_days_between_dates (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cdbd_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output cdbd_pkg::out_t  out_data
);

    cdbd_pkg::state_t state_reg, state_next;
    cdbd_pkg::in_t    item_reg, item_next;
    logic             entry_ok_reg, entry_ok_next;
    logic [3:0]       cur_month_reg, cur_month_next;
    logic [11:0]      cur_year_reg, cur_year_next;
    logic [16:0]      acc_reg, acc_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [16:0]      res_count_reg, res_count_next;
    logic             out_valid_reg, out_valid_next;
    cdbd_pkg::out_t   out_data_reg, out_data_next;

    logic [3:0]  unit_month;
    logic [11:0] unit_year;
    logic [4:0]  unit_days;
    logic [5:0]  chk_day;
    logic        date_ok;
    logic        exit_later;

    // shared month length unit
    cdbd_month_len u_month_len (
        .month (unit_month),
        .year  (unit_year),
        .days  (unit_days)
    );

    // operand select for the shared unit
    always_comb
    begin
        unique case (state_reg)
            cdbd_pkg::ST_CHK_ENTRY:
            begin
                unit_month = item_reg.entry_month;
                unit_year  = item_reg.entry_year;
                chk_day    = item_reg.entry_day;
            end
            cdbd_pkg::ST_CHK_EXIT:
            begin
                unit_month = item_reg.exit_month;
                unit_year  = item_reg.exit_year;
                chk_day    = item_reg.exit_day;
            end
            default:
            begin
                unit_month = cur_month_reg;
                unit_year  = cur_year_reg;
                chk_day    = item_reg.exit_day;
            end
        endcase
    end

    // date validity for the date on the unit
    assign date_ok = (unit_year >= cdbd_pkg::YEAR_MIN) && (unit_year <= cdbd_pkg::YEAR_MAX)
                     && (unit_month >= cdbd_pkg::MONTH_JAN)
                     && (unit_month <= cdbd_pkg::MONTH_DEC)
                     && (chk_day != 6'd0) && (chk_day <= {1'b0, unit_days});

    // exit strictly later: year, month, day compared as one key
    assign exit_later = {item_reg.entry_year, item_reg.entry_month, item_reg.entry_day}
                        < {item_reg.exit_year, item_reg.exit_month, item_reg.exit_day};

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        entry_ok_next   = entry_ok_reg;
        cur_month_next  = cur_month_reg;
        cur_year_next   = cur_year_reg;
        acc_next        = acc_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        in_ready        = 1'b0;

        unique case (state_reg)
            cdbd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = cdbd_pkg::ST_CHK_ENTRY;
                end
            end
            cdbd_pkg::ST_CHK_ENTRY:
            begin
                entry_ok_next = date_ok;
                state_next    = cdbd_pkg::ST_CHK_EXIT;
            end
            cdbd_pkg::ST_CHK_EXIT:
            begin
                priority if (!(entry_ok_reg && date_ok))
                begin
                    res_status_next = cdbd_pkg::STATUS_INVALID;
                    res_count_next  = 17'd0;
                    state_next      = cdbd_pkg::ST_DONE;
                end
                else if (!exit_later)
                begin
                    res_status_next = cdbd_pkg::STATUS_ORDER;
                    res_count_next  = 17'd0;
                    state_next      = cdbd_pkg::ST_DONE;
                end
                else
                begin
                    cur_month_next = item_reg.entry_month;
                    cur_year_next  = item_reg.entry_year;
                    acc_next       = {11'd0, item_reg.exit_day};
                    state_next     = cdbd_pkg::ST_WALK;
                end
            end
            cdbd_pkg::ST_WALK:
            begin
                // stop on the exit month, else add this month and step on
                if ((cur_month_reg == item_reg.exit_month) && (cur_year_reg == item_reg.exit_year))
                begin
                    res_status_next = cdbd_pkg::STATUS_OK;
                    res_count_next  = acc_reg - {11'd0, item_reg.entry_day};
                    state_next      = cdbd_pkg::ST_DONE;
                end
                else
                begin
                    acc_next = acc_reg + {12'd0, unit_days};
                    if (cur_month_reg == cdbd_pkg::MONTH_DEC)
                    begin
                        cur_month_next = cdbd_pkg::MONTH_JAN;
                        cur_year_next  = cur_year_reg + 12'd1;
                    end
                    else
                    begin
                        cur_month_next = cur_month_reg + 4'd1;
                    end
                end
            end
            cdbd_pkg::ST_DONE:
            begin
                // load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.status    = res_status_reg;
                    out_data_next.day_count = res_count_reg;
                    out_valid_next          = 1'b1;
                    state_next              = cdbd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdbd_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdbd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        entry_ok_reg   <= entry_ok_next;
        cur_month_reg  <= cur_month_next;
        cur_year_reg   <= cur_year_next;
        acc_reg        <= acc_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        out_data_reg   <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/cdbd_month_len.sv
// ----------------------------------------------------------------------------
// cdbd_month_len
// Month length unit: days in a given month of a given year, Gregorian rule.
// ----------------------------------------------------------------------------
module cdbd_month_len (
    input  logic [3:0]  month,
    input  logic [11:0] year,
    output logic [4:0]  days
);

    logic leap;

    // leap rule inside 1900..2100: divisible by 4, except the two century
    // years that are not divisible by 400
    assign leap = (year[1:0] == 2'b00) && (year != cdbd_pkg::YEAR_MIN)
                  && (year != cdbd_pkg::YEAR_MAX);

    // month length lookup
    always_comb
    begin
        unique case (month)
            cdbd_pkg::MONTH_FEB: days = leap ? cdbd_pkg::DAYS_FEB_L : cdbd_pkg::DAYS_FEB;
            cdbd_pkg::MONTH_APR,
            cdbd_pkg::MONTH_JUN,
            cdbd_pkg::MONTH_SEP,
            cdbd_pkg::MONTH_NOV: days = cdbd_pkg::DAYS_SHORT;
            default:             days = cdbd_pkg::DAYS_LONG;
        endcase
    end

endmodule

>>> rtl/cdbd_checker.sv
// ----------------------------------------------------------------------------
// cdbd_checker
// Port-level checks for the days-between-dates block, bound to the top level.
// ----------------------------------------------------------------------------
module cdbd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input cdbd_pkg::out_t out_data
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    // error results carry a zero count
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != cdbd_pkg::STATUS_OK) |-> out_data.day_count == 17'd0)
        else $error("nonzero count on error status");

    // ok results carry a positive count and status stays in its code set
    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == cdbd_pkg::STATUS_OK && out_data.day_count != 17'd0)
                   || out_data.status == cdbd_pkg::STATUS_INVALID
                   || out_data.status == cdbd_pkg::STATUS_ORDER)
        else $error("bad status or zero count on ok");

    // busy right after an item is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accepting an item");

endmodule

bind calendar_days_between_dates cdbd_checker u_cdbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> tb/calendar_days_between_dates_test.sv
// ----------------------------------------------------------------------------
// calendar_days_between_dates_test
// Drives date pairs into the days-between-dates block over a valid/ready
// channel and checks every result against an in-bench calendar predictor.
// It covers directed corner dates, well-formed random pairs, corrupted and
// raw bit patterns, and a back-to-back run. Both sides idle at random.
// ----------------------------------------------------------------------------
module calendar_days_between_dates_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 12000;
    localparam int unsigned DRAIN_CYCLES   = 50;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    cdbd_pkg::in_t   in_data;
    logic            out_valid;
    logic            out_ready;
    cdbd_pkg::out_t  out_data;

    cdbd_pkg::out_t span_queue[$];
    int unsigned    error_count = 0;
    int unsigned    idle_cycles = 0;
    int unsigned    ready_hold  = 0;
    bit             idling_on   = 1'b1;

    calendar_days_between_dates i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock, 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // gregorian calendar helpers
    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        if (m == cdbd_pkg::MONTH_FEB)
            return leap_year(y) ? cdbd_pkg::DAYS_FEB_L : cdbd_pkg::DAYS_FEB;
        if (m == cdbd_pkg::MONTH_APR || m == cdbd_pkg::MONTH_JUN
            || m == cdbd_pkg::MONTH_SEP || m == cdbd_pkg::MONTH_NOV)
            return cdbd_pkg::DAYS_SHORT;
        return cdbd_pkg::DAYS_LONG;
    endfunction

    function automatic bit date_ok(input int unsigned d, input int unsigned m,
                                   input int unsigned y);
        if (y < cdbd_pkg::YEAR_MIN || y > cdbd_pkg::YEAR_MAX)
            return 1'b0;
        if (m < cdbd_pkg::MONTH_JAN || m > cdbd_pkg::MONTH_DEC)
            return 1'b0;
        return (d >= 1) && (d <= month_days(m, y));
    endfunction

    // days elapsed since the first of january of the earliest year
    function automatic int unsigned days_since_epoch(input int unsigned d,
                                                     input int unsigned m,
                                                     input int unsigned y);
        int unsigned n;
        n = 0;
        for (int unsigned yy = cdbd_pkg::YEAR_MIN; yy < y; yy++)
            n += leap_year(yy) ? 366 : 365;
        for (int unsigned mm = cdbd_pkg::MONTH_JAN; mm < m; mm++)
            n += month_days(mm, y);
        return n + d - 1;
    endfunction

    // expected result for one date pair
    function automatic cdbd_pkg::out_t compute_day_span(input cdbd_pkg::in_t p);
        cdbd_pkg::out_t r;
        int unsigned    first_day;
        int unsigned    last_day;
        r.status    = cdbd_pkg::STATUS_OK;
        r.day_count = '0;
        if (!date_ok(p.entry_day, p.entry_month, p.entry_year) ||
            !date_ok(p.exit_day, p.exit_month, p.exit_year))
        begin
            r.status = cdbd_pkg::STATUS_INVALID;
            return r;
        end
        first_day = days_since_epoch(p.entry_day, p.entry_month, p.entry_year);
        last_day  = days_since_epoch(p.exit_day, p.exit_month, p.exit_year);
        if (last_day <= first_day)
            r.status = cdbd_pkg::STATUS_ORDER;
        else
            r.day_count = 17'(last_day - first_day);
        return r;
    endfunction

    // idle length: mostly short, a few long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!idling_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 200);
    endfunction

    function automatic cdbd_pkg::in_t make_pair(input int unsigned ed, input int unsigned em,
                                                input int unsigned ey, input int unsigned xd,
                                                input int unsigned xm, input int unsigned xy);
        cdbd_pkg::in_t p;
        p.entry_day   = 6'(ed);
        p.entry_month = 4'(em);
        p.entry_year  = 12'(ey);
        p.exit_day    = 6'(xd);
        p.exit_month  = 4'(xm);
        p.exit_year   = 12'(xy);
        return p;
    endfunction

    // two legal dates, near, wide apart or equal, in either order
    function automatic cdbd_pkg::in_t random_valid_pair();
        int unsigned ed, em, ey, xd, xm, xy, roll;
        ey   = $urandom_range(cdbd_pkg::YEAR_MIN, cdbd_pkg::YEAR_MAX);
        em   = $urandom_range(cdbd_pkg::MONTH_JAN, cdbd_pkg::MONTH_DEC);
        ed   = $urandom_range(1, month_days(em, ey));
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return make_pair(ed, em, ey, ed, em, ey);
        if (roll < 60)
        begin
            xy = ey + $urandom_range(0, 1);
            if (xy > cdbd_pkg::YEAR_MAX)
                xy = cdbd_pkg::YEAR_MAX;
        end
        else
            xy = $urandom_range(cdbd_pkg::YEAR_MIN, cdbd_pkg::YEAR_MAX);
        xm = $urandom_range(cdbd_pkg::MONTH_JAN, cdbd_pkg::MONTH_DEC);
        xd = $urandom_range(1, month_days(xm, xy));
        // keep most pairs in order so the walk is exercised
        if ($urandom_range(0, 99) < 25)
            return make_pair(xd, xm, xy, ed, em, ey);
        return make_pair(ed, em, ey, xd, xm, xy);
    endfunction

    // legal pair with one field pushed out of range
    function automatic cdbd_pkg::in_t corrupt_pair(input cdbd_pkg::in_t p);
        int unsigned which;
        logic [5:0]  bad_day;
        logic [3:0]  bad_month;
        logic [11:0] bad_year;
        which = $urandom_range(0, 5);
        if ($urandom_range(0, 1) == 0)
            bad_day = 6'd0;
        else
            bad_day = 6'($urandom_range(month_days(p.entry_month, p.entry_year) + 1, 63));
        bad_month = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
        bad_year  = ($urandom_range(0, 1) == 0)
                    ? 12'($urandom_range(0, cdbd_pkg::YEAR_MIN - 1))
                    : 12'($urandom_range(cdbd_pkg::YEAR_MAX + 1, 4095));
        case (which)
            0: p.entry_day   = bad_day;
            1: p.entry_month = bad_month;
            2: p.entry_year  = bad_year;
            3: p.exit_day    = (bad_day == 6'd0) ? 6'd0 : 6'd32 + bad_day[4:0];
            4: p.exit_month  = bad_month;
            default: p.exit_year = bad_year;
        endcase
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // offer one item and hold it until accepted; entered and left at a falling edge
    task automatic send_date_pair(input cdbd_pkg::in_t item);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        span_queue.push_back(compute_day_span(item));
        @(negedge clk);
    endtask

    // corner dates, leap rules and every status
    task automatic test_directed();
        send_date_pair(make_pair(1, 1, 1900, 31, 12, 2100));
        send_date_pair(make_pair(1, 1, 1900, 2, 1, 1900));
        send_date_pair(make_pair(31, 12, 2100, 1, 1, 1900));
        send_date_pair(make_pair(15, 6, 2000, 15, 6, 2000));
        send_date_pair(make_pair(28, 2, 2000, 1, 3, 2000));
        send_date_pair(make_pair(29, 2, 2000, 1, 3, 2000));
        send_date_pair(make_pair(29, 2, 1900, 1, 3, 1900));
        send_date_pair(make_pair(29, 2, 2004, 29, 2, 2008));
        send_date_pair(make_pair(1, 1, 2099, 29, 2, 2100));
        send_date_pair(make_pair(28, 2, 2100, 1, 3, 2100));
        send_date_pair(make_pair(30, 2, 2000, 1, 3, 2000));
        send_date_pair(make_pair(31, 4, 2010, 1, 5, 2010));
        send_date_pair(make_pair(30, 11, 2010, 31, 12, 2010));
        send_date_pair(make_pair(0, 1, 1950, 1, 1, 1960));
        send_date_pair(make_pair(63, 15, 4095, 63, 15, 4095));
        send_date_pair(make_pair(0, 0, 0, 0, 0, 0));
        send_date_pair(make_pair(1, 0, 1950, 1, 1, 1960));
        send_date_pair(make_pair(1, 13, 1950, 1, 1, 1960));
        send_date_pair(make_pair(1, 1, 1899, 1, 1, 1960));
        send_date_pair(make_pair(1, 1, 1950, 1, 1, 2101));
        send_date_pair(make_pair(1, 1, 1950, 32, 1, 1960));
        // invalid date wins over a reversed order
        send_date_pair(make_pair(1, 1, 2050, 0, 1, 1950));
        send_date_pair(make_pair(10, 3, 1999, 9, 3, 1999));
        send_date_pair(make_pair(31, 12, 1999, 1, 1, 2000));
    endtask

    task automatic test_well_formed(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_date_pair(random_valid_pair());
    endtask

    // corrupted pairs mixed with raw bit patterns
    task automatic test_broken(input int unsigned count);
        logic [63:0] raw;
        for (int unsigned i = 0; i < count; i++)
        begin
            raw = {$urandom, $urandom};
            if ($urandom_range(0, 1) == 0)
                send_date_pair(corrupt_pair(random_valid_pair()));
            else
                send_date_pair(cdbd_pkg::in_t'(raw[43:0]));
        end
    endtask

    task automatic test_back_to_back(input int unsigned count);
        idling_on = 1'b0;
        for (int unsigned i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_date_pair(corrupt_pair(random_valid_pair()));
            else
                send_date_pair(random_valid_pair());
        end
        idling_on = 1'b1;
    endtask

    // stimulus sequence
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_well_formed(150);
        test_broken(40);
        test_back_to_back(30);

        in_valid <= 1'b0;
        while (span_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (ready_hold != 0)
        begin
            out_ready  <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_hold <= pick_gap();
        end
    end

    // compare each accepted result with the oldest expected one
    always @(posedge clk)
    begin
        cdbd_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (span_queue.size() == 0)
                report_mismatch($sformatf("result with nothing pending, status %0d count %0d",
                                          out_data.status, out_data.day_count));
            else
            begin
                want = span_queue.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              out_data.status, want.status));
                if (out_data.day_count !== want.day_count)
                    report_mismatch($sformatf("day_count got %0d want %0d",
                                              out_data.day_count, want.day_count));
            end
        end
    end

    // stop when no item moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
